[rtl/hysteresis_onoff_controller_macros.svh]
// Assertion macros for the controller RTL.
`ifndef HYSTERESIS_ONOFF_CONTROLLER_MACROS_SVH
`define HYSTERESIS_ONOFF_CONTROLLER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define HOC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define HOC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hoc_pkg.sv]
// Types and constants of the hysteresis on/off controller.
package hoc_pkg;

    localparam int TIME_BITS       = 32;
    localparam int VALUE_BITS      = 16;
    localparam int VALUE_FRAC_BITS = 4;
    localparam int HYST_BITS       = VALUE_BITS - 1;
    localparam int CFG_BITS        = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;
    localparam int CNT_BITS        = $clog2(TIME_BITS);

    localparam logic [VALUE_BITS-1:0] SETPOINT_RESET = VALUE_BITS'(75 << VALUE_FRAC_BITS);
    localparam logic [TIME_BITS-1:0]  INTERVAL_RESET = TIME_BITS'(1000);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;

    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_ON_HYST  = 3'd1;
    localparam logic [2:0] REG_OFF_HYST = 3'd2;
    localparam logic [2:0] REG_MIN_ON   = 3'd3;
    localparam logic [2:0] REG_MIN_OFF  = 3'd4;
    localparam logic [2:0] REG_INTERVAL = 3'd5;

    localparam logic [1:0] TR_NONE = 2'd0;
    localparam logic [1:0] TR_ON   = 2'd1;
    localparam logic [1:0] TR_OFF  = 2'd2;

    typedef struct packed {
        logic [2:0]                   opcode;
        logic [TIME_BITS-1:0]         now_ms;
        logic signed [VALUE_BITS-1:0] process_value;
        logic                         value_valid;
    } in_item_t;

    typedef struct packed {
        logic       valve_on;
        logic       pump_on;
        logic       is_running;
        logic [1:0] transition;
        logic       status_due;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic eval;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       stat_due;
        logic       div_done;
        logic       out_free;
    } sts_t;

endpackage

[rtl/hoc_div.sv]
// Bit-serial restoring divider giving the remainder of time over interval.
module hoc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hoc_pkg::TIME_BITS-1:0] dividend,
    input  logic [hoc_pkg::TIME_BITS-1:0] divisor,
    output logic                          done,
    output logic [hoc_pkg::TIME_BITS-1:0] rem
);
    import hoc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] dvd_reg;
    logic [TIME_BITS-1:0] dsr_reg;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic [TIME_BITS-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign rem_next = diff[TIME_BITS] ? trial[TIME_BITS-1:0] : diff[TIME_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(TIME_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[TIME_BITS-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/hoc_datapath.sv]
// Datapath: configuration, controller state, switching rule and result register.
module hoc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [hoc_pkg::CFG_BITS-1:0]  cfg_data,
    input  hoc_pkg::in_item_t             in_data,
    output hoc_pkg::out_item_t            out_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  hoc_pkg::cmd_t                 cmd,
    output hoc_pkg::sts_t                 sts
);
    import hoc_pkg::*;

    logic signed [VALUE_BITS-1:0] setpoint_reg;
    logic [HYST_BITS-1:0]         on_hyst_reg;
    logic [HYST_BITS-1:0]         off_hyst_reg;
    logic [TIME_BITS-1:0]         min_on_reg;
    logic [TIME_BITS-1:0]         min_off_reg;
    logic [TIME_BITS-1:0]         interval_reg;

    logic                 valve_reg;
    logic                 pump_reg;
    logic                 running_reg;
    logic                 saved_reg;
    logic [TIME_BITS-1:0] dwell_reg;
    logic [TIME_BITS-1:0] pause_reg;
    logic [TIME_BITS-1:0] stat_reg;
    logic [1:0]           tr_reg;
    logic                 due_reg;
    logic                 out_valid_reg;
    in_item_t             item_reg;
    out_item_t            out_reg;

    logic [TIME_BITS-1:0]         now;
    logic [TIME_BITS-1:0]         iv;
    logic [TIME_BITS-1:0]         dcyc;
    logic [TIME_BITS-1:0]         dstat;
    logic signed [VALUE_BITS-1:0] pv;
    logic signed [VALUE_BITS:0]   pv_ext;
    logic signed [VALUE_BITS:0]   sp_ext;
    logic signed [VALUE_BITS:0]   sp_hi;
    logic signed [VALUE_BITS:0]   sp_lo;
    logic                         go_on;
    logic                         go_off;
    logic                         stat_due;
    logic                         div_done;
    logic [TIME_BITS-1:0]         div_rem;

    assign now    = item_reg.now_ms;
    assign iv     = (interval_reg == '0) ? TIME_BITS'(1) : interval_reg;
    assign dcyc   = now - dwell_reg;
    assign dstat  = now - stat_reg;
    assign pv     = item_reg.value_valid ? item_reg.process_value : '0;
    assign pv_ext = $signed({pv[VALUE_BITS-1], pv});
    assign sp_ext = $signed({setpoint_reg[VALUE_BITS-1], setpoint_reg});
    assign sp_hi  = sp_ext + $signed({2'b00, on_hyst_reg});
    assign sp_lo  = sp_ext - $signed({2'b00, off_hyst_reg});
    assign go_on  = (pv_ext > sp_hi) && (dcyc >= min_off_reg);
    assign go_off = (pv == '0) || ((pv_ext < sp_lo) && (dcyc >= min_on_reg));
    assign stat_due = running_reg && (dstat > iv);

    hoc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (now),
        .divisor  (iv),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RESET;
            on_hyst_reg   <= '0;
            off_hyst_reg  <= '0;
            min_on_reg    <= '0;
            min_off_reg   <= '0;
            interval_reg  <= INTERVAL_RESET;
            valve_reg     <= 1'b0;
            pump_reg      <= 1'b0;
            running_reg   <= 1'b0;
            saved_reg     <= 1'b0;
            dwell_reg     <= '0;
            pause_reg     <= '0;
            stat_reg      <= '0;
            tr_reg        <= TR_NONE;
            due_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SETPOINT: setpoint_reg <= cfg_data[VALUE_BITS-1:0];
                    REG_ON_HYST:  on_hyst_reg  <= cfg_data[HYST_BITS-1:0];
                    REG_OFF_HYST: off_hyst_reg <= cfg_data[HYST_BITS-1:0];
                    REG_MIN_ON:   min_on_reg   <= cfg_data[TIME_BITS-1:0];
                    REG_MIN_OFF:  min_off_reg  <= cfg_data[TIME_BITS-1:0];
                    REG_INTERVAL: interval_reg <= cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end

            if (cmd.capture)
            begin
                tr_reg  <= TR_NONE;
                due_reg <= 1'b0;
            end

            if (cmd.apply)
            begin
                unique case (item_reg.opcode)
                    OP_START:
                    begin
                        running_reg <= 1'b1;
                        saved_reg   <= 1'b0;
                        valve_reg   <= item_reg.value_valid && (pv_ext >= sp_ext);
                        pump_reg    <= 1'b1;
                        dwell_reg   <= now;
                        due_reg     <= 1'b1;
                    end
                    OP_STOP:
                    begin
                        pump_reg    <= 1'b0;
                        valve_reg   <= 1'b0;
                        running_reg <= 1'b0;
                    end
                    OP_PAUSE:
                    begin
                        running_reg <= 1'b0;
                        saved_reg   <= valve_reg;
                        pump_reg    <= 1'b0;
                        valve_reg   <= 1'b0;
                        pause_reg   <= now;
                    end
                    OP_RESUME:
                    begin
                        running_reg <= 1'b1;
                        dwell_reg   <= dwell_reg + (now - pause_reg);
                        pump_reg    <= 1'b1;
                        valve_reg   <= saved_reg;
                    end
                    default: ;
                endcase
            end

            if (cmd.eval && running_reg)
            begin
                if (!valve_reg)
                begin
                    if (go_on)
                    begin
                        valve_reg <= 1'b1;
                        dwell_reg <= now;
                        tr_reg    <= TR_ON;
                    end
                end
                else if (go_off)
                begin
                    valve_reg <= 1'b0;
                    dwell_reg <= now;
                    tr_reg    <= TR_OFF;
                end
                if (stat_due)
                    due_reg <= 1'b1;
            end

            if (div_done)
                stat_reg <= now - div_rem;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.out_load)
        begin
            out_reg.valve_on   <= valve_reg;
            out_reg.pump_on    <= pump_reg;
            out_reg.is_running <= running_reg;
            out_reg.transition <= tr_reg;
            out_reg.status_due <= due_reg;
        end
    end

    assign out_data     = out_reg;
    assign out_valid    = out_valid_reg;
    assign sts.op       = item_reg.opcode;
    assign sts.stat_due = stat_due;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

[rtl/hoc_ctrl.sv]
// Sequencer: steps one event through apply, evaluate, interval rounding and result load as its opcode needs.
`include "hysteresis_onoff_controller_macros.svh"

module hoc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hoc_pkg::sts_t sts,
    output hoc_pkg::cmd_t cmd
);
    import hoc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                case (sts.op) inside
                    OP_TICK, OP_RESUME: state_next = ST_EVAL;
                    OP_START:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (sts.stat_due)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `HOC_ASSERT_NXT(a_div_start_enters_div, cmd.div_start, state_reg == ST_DIV, "divider started outside rounding step")
    `HOC_ASSERT_IMP(a_div_done_in_div, sts.div_done, state_reg == ST_DIV, "divider finished while not awaited")
    `HOC_ASSERT_NXT(a_load_returns_idle, cmd.out_load, state_reg == ST_IDLE && sts.op == $past(sts.op), "result loaded without return to idle")

endmodule

[rtl/hysteresis_onoff_controller.sv]
// Top level of the hysteresis on/off valve controller.
// One event is taken at a time. Stop, pause and unknown opcodes step through apply and
// result load; tick and resume step through apply, evaluate and result load. Start, and a
// tick or resume that finds a status interval passed, also pass a rounding step in which
// the status marker is rounded down to the interval by a one-bit-per-cycle remainder
// unit of 32 steps. The result load waits until the output register is free.
// The result sits in an output register, so a new event is taken as soon as the
// block is back in idle even while the previous result waits for its transfer.
// Configuration writes take effect at once and belong in idle periods.
module hysteresis_onoff_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [hoc_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hoc_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hoc_pkg::out_item_t           out_data
);
    import hoc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hoc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
